// ===== rtl/e2c_pkg.sv =====
package e2c_pkg;

	// field widths
	localparam int EPOCH_W  = 32;
	localparam int OFFSET_W = 4;
	localparam int ADJ_W    = 33;
	localparam int DAYS_W   = 17;
	localparam int SOD_W    = 17;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int MDAY_W   = 5;
	localparam int WDAY_W   = 3;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int TDATA_W  = 48;

	// calendar constants
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned DAYS_PER_CYCLE = 1461;
	localparam int unsigned END_DAYS      = 47482;
	localparam int unsigned EPOCH_YEAR    = 1970;
	localparam int unsigned DAYS_COMMON   = 365;
	localparam int unsigned DAYS_LEAP     = 366;
	localparam int unsigned EPOCH_WDAY    = 3;
	localparam int unsigned WEEK_DAYS     = 7;

	// reciprocals: m = ceil(2^(n+l) / d), exact for x < 2^n
	// day: (adj >> 7) / 675, n = 26, shift 36
	localparam int DAY_SH = 36;
	localparam logic [26:0] DAY_RECIP = 27'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);
	// four-year cycle: days / 1461, n = 16, shift 27
	localparam int CYC_SH = 27;
	localparam logic [16:0] CYC_RECIP =
		17'(((64'd1 << CYC_SH) + 64'(DAYS_PER_CYCLE) - 64'd1) / 64'(DAYS_PER_CYCLE));
	// week: (days + 3) / 7, n = 17, shift 20
	localparam int WK_SH = 20;
	localparam logic [17:0] WK_RECIP =
		18'(((64'd1 << WK_SH) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));
	// hour: (sod >> 4) / 225, n = 13, shift 21
	localparam int HOUR_SH = 21;
	localparam logic [13:0] HOUR_RECIP = 14'(((64'd1 << HOUR_SH) + 64'd224) / 64'd225);
	// minute: (rem >> 2) / 15, n = 10, shift 14
	localparam int MIN_SH = 14;
	localparam logic [10:0] MIN_RECIP = 11'(((64'd1 << MIN_SH) + 64'd14) / 64'd15);

	// days before each month, with the year length as last entry
	localparam logic [8:0] CUM_COMMON [13] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
	};
	localparam logic [8:0] CUM_LEAP [13] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
		9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
	};

	// valid stages from the input register to the queue write
	localparam int PIPE_STAGES = 11;

	// result queue
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month_num;
		logic [MDAY_W-1:0]  day_of_month;
		logic [WDAY_W-1:0]  week_day;
	} e2c_date_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour_val;
		logic [MIN_W-1:0]  minute_val;
		logic [SEC_W-1:0]  second_val;
	} e2c_clock_t;

	typedef struct packed {
		e2c_date_t  date;
		e2c_clock_t tod;
		logic       out_of_range;
	} e2c_result_t;

endpackage

// ===== rtl/e2c_front.sv =====
module e2c_front import e2c_pkg::*; (
	input  logic                clk,
	input  logic [EPOCH_W-1:0]  epoch,
	input  logic [OFFSET_W-1:0] utc_offset,
	output logic [DAYS_W-1:0]   days,
	output logic [SOD_W-1:0]    sod,
	output logic                oor
);

	logic [ADJ_W-1:0]  adj_s1, adj_s2, adj_s3, adj_s4;
	logic [52:0]       dprod_s2;
	logic [DAYS_W-1:0] days_s3, days_s4, days_s5;
	logic [ADJ_W-1:0]  dsec_s4;
	logic [SOD_W-1:0]  sod_s5;
	logic              oor_s5;

	always_ff @(posedge clk) begin
		// offset added at full precision
		adj_s1   <= ADJ_W'(epoch) + ADJ_W'(utc_offset) * ADJ_W'(SECS_PER_HOUR);
		// 86400 = 128 * 675
		dprod_s2 <= 53'(adj_s1[ADJ_W-1:7]) * 53'(DAY_RECIP);
		adj_s2   <= adj_s1;
		days_s3  <= dprod_s2[DAY_SH+DAYS_W-1:DAY_SH];
		adj_s3   <= adj_s2;
		dsec_s4  <= ADJ_W'(34'(days_s3) * 34'(SECS_PER_DAY));
		days_s4  <= days_s3;
		adj_s4   <= adj_s3;
		sod_s5   <= SOD_W'(adj_s4 - dsec_s4);
		days_s5  <= days_s4;
		oor_s5   <= (days_s4 >= DAYS_W'(END_DAYS));
	end

	assign days = days_s5;
	assign sod  = sod_s5;
	assign oor  = oor_s5;

endmodule

// ===== rtl/e2c_date.sv =====
module e2c_date import e2c_pkg::*; (
	input  logic              clk,
	input  logic [DAYS_W-1:0] days,
	input  logic              oor_in,
	output e2c_date_t         date,
	output logic              oor_out
);

	logic [32:0] cprod_s1;
	logic [34:0] wprod_s1;
	logic [15:0] days_s1, days_s2;
	logic        oor_s1, oor_s2, oor_s3, oor_s4, oor_s5, oor_s6;
	logic [5:0]  cq_s2, cq_s3;
	logic [13:0] wq_s2;
	logic [10:0] r_s3;
	logic [WDAY_W-1:0] wd_s3, wd_s4, wd_s5;
	logic [YEAR_W-1:0] yr_s4, yr_s5;
	logic [8:0]  rr_s4;
	logic        leap_s4;
	logic [MONTH_W-1:0] mon_s5;
	logic [MDAY_W-1:0]  mday_s5;
	e2c_date_t   date_s6;

	logic [1:0]  yo_c;
	logic [8:0]  rr_c;
	logic        leap_c;
	logic [MONTH_W-1:0] mon_c;
	logic [8:0]  base_c;
	logic [16:0] wd_full_c;

	// year within the four-year cycle: 365, 365, 366, 365
	always_comb begin
		priority if (r_s3 < 11'(DAYS_COMMON)) begin
			yo_c   = 2'd0;
			rr_c   = 9'(r_s3);
			leap_c = 1'b0;
		end else if (r_s3 < 11'(2 * DAYS_COMMON)) begin
			yo_c   = 2'd1;
			rr_c   = 9'(r_s3 - 11'(DAYS_COMMON));
			leap_c = 1'b0;
		end else if (r_s3 < 11'(2 * DAYS_COMMON + DAYS_LEAP)) begin
			yo_c   = 2'd2;
			rr_c   = 9'(r_s3 - 11'(2 * DAYS_COMMON));
			leap_c = 1'b1;
		end else begin
			yo_c   = 2'd3;
			rr_c   = 9'(r_s3 - 11'(2 * DAYS_COMMON + DAYS_LEAP));
			leap_c = 1'b0;
		end
	end

	// first month whose end lies past the day of year
	always_comb begin
		mon_c  = 4'd12;
		base_c = leap_s4 ? CUM_LEAP[11] : CUM_COMMON[11];
		for (int i = 11; i >= 0; i--) begin
			if (rr_s4 < (leap_s4 ? CUM_LEAP[i+1] : CUM_COMMON[i+1])) begin
				mon_c  = 4'(i + 1);
				base_c = leap_s4 ? CUM_LEAP[i] : CUM_COMMON[i];
			end
		end
	end

	assign wd_full_c = 17'(days_s2) + 17'(EPOCH_WDAY) - 17'(wq_s2) * 17'(WEEK_DAYS);

	always_ff @(posedge clk) begin
		cprod_s1 <= 33'(days[15:0]) * 33'(CYC_RECIP);
		wprod_s1 <= 35'(17'(days[15:0]) + 17'(EPOCH_WDAY)) * 35'(WK_RECIP);
		days_s1  <= days[15:0];
		oor_s1   <= oor_in;

		cq_s2    <= cprod_s1[CYC_SH+5:CYC_SH];
		wq_s2    <= wprod_s1[WK_SH+13:WK_SH];
		days_s2  <= days_s1;
		oor_s2   <= oor_s1;

		r_s3     <= 11'(days_s2 - 16'(cq_s2) * 16'(DAYS_PER_CYCLE));
		wd_s3    <= WDAY_W'(wd_full_c) + WDAY_W'(1);
		cq_s3    <= cq_s2;
		oor_s3   <= oor_s2;

		yr_s4    <= YEAR_W'(EPOCH_YEAR) + YEAR_W'({cq_s3, 2'b00}) + YEAR_W'(yo_c);
		rr_s4    <= rr_c;
		leap_s4  <= leap_c;
		wd_s4    <= wd_s3;
		oor_s4   <= oor_s3;

		mon_s5   <= mon_c;
		mday_s5  <= MDAY_W'(rr_s4 - base_c + 9'd1);
		yr_s5    <= yr_s4;
		wd_s5    <= wd_s4;
		oor_s5   <= oor_s4;

		// past the end of 2099 every date field reads zero
		if (oor_s5) begin
			date_s6 <= '0;
		end else begin
			date_s6.year         <= yr_s5;
			date_s6.month_num    <= mon_s5;
			date_s6.day_of_month <= mday_s5;
			date_s6.week_day     <= wd_s5;
		end
		oor_s6   <= oor_s5;
	end

	assign date    = date_s6;
	assign oor_out = oor_s6;

endmodule

// ===== rtl/e2c_clock.sv =====
module e2c_clock import e2c_pkg::*; (
	input  logic             clk,
	input  logic [SOD_W-1:0] sod,
	output e2c_clock_t       tod
);

	logic [26:0]       hprod_s1;
	logic [SOD_W-1:0]  sod_s1, sod_s2;
	logic [HOUR_W-1:0] hour_s2, hour_s3, hour_s4, hour_s5, hour_s6;
	logic [11:0]       rem_s3, rem_s4, rem_s5;
	logic [20:0]       mprod_s4;
	logic [MIN_W-1:0]  min_s5, min_s6;
	logic [SEC_W-1:0]  sec_s6;

	always_ff @(posedge clk) begin
		// 3600 = 16 * 225
		hprod_s1 <= 27'(sod[SOD_W-1:4]) * 27'(HOUR_RECIP);
		sod_s1   <= sod;
		hour_s2  <= hprod_s1[HOUR_SH+HOUR_W-1:HOUR_SH];
		sod_s2   <= sod_s1;
		rem_s3   <= 12'(sod_s2 - SOD_W'(hour_s2) * SOD_W'(SECS_PER_HOUR));
		hour_s3  <= hour_s2;
		// 60 = 4 * 15
		mprod_s4 <= 21'(rem_s3[11:2]) * 21'(MIN_RECIP);
		rem_s4   <= rem_s3;
		hour_s4  <= hour_s3;
		min_s5   <= mprod_s4[MIN_SH+MIN_W-1:MIN_SH];
		rem_s5   <= rem_s4;
		hour_s5  <= hour_s4;
		sec_s6   <= SEC_W'(rem_s5 - 12'(min_s5) * 12'(SECS_PER_MIN));
		min_s6   <= min_s5;
		hour_s6  <= hour_s5;
	end

	assign tod.hour_val   = hour_s6;
	assign tod.minute_val = min_s6;
	assign tod.second_val = sec_s6;

endmodule

// ===== rtl/e2c_fifo.sv =====
module e2c_fifo import e2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  e2c_result_t wr_data,
	input  logic        rd_en,
	output e2c_result_t rd_data,
	output logic        not_empty
);

	e2c_result_t        mem_q [FIFO_DEPTH];
	e2c_result_t        rd_data_q;
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_nxt;
	logic [FIFO_AW:0]   count_q;

	assign rd_ptr_nxt = rd_en ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;

	// head entry kept in a register; a write into the head slot goes straight through
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
		if (wr_en && (wr_ptr_q == rd_ptr_nxt)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem_q[rd_ptr_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			rd_ptr_q <= rd_ptr_nxt;
			count_q <= count_q + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
		end
	end

	assign rd_data   = rd_data_q;
	assign not_empty = (count_q != '0);

endmodule

// ===== rtl/epoch_to_calendar.sv =====
// epoch_to_calendar: unix seconds to calendar date and time of day
//
// input stream s_*: one request per beat, s_tdata[31:0] = epoch_seconds
// output stream m_*: one result per request, in request order
//   m_tdata fields from bit 0: year, month_num, day_of_month, week_day,
//   hour_val, minute_val, second_val; m_tuser = out_of_range
// cfg_wr_en / cfg_wr_data: whole-hour utc offset, written while idle
//
// throughput: one request per cycle while fewer than 16 requests are outstanding,
// set by a fully pipelined datapath with no shared unit and no loop-carried state
// the accepted epoch passes the input register, the front, date and clock
// stages and the valid chain; m_tvalid rises on the edge that queues the result
// when the receiver stalls, results collect in a 16-entry queue; the
// input keeps taking requests until 16 are accepted and not yet delivered
// reset clears the offset to 0 and drops everything in flight or queued
module epoch_to_calendar import e2c_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// config
	input  logic                cfg_wr_en,
	input  logic [OFFSET_W-1:0] cfg_wr_data,   // utc_offset_hours
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [EPOCH_W-1:0]  s_tdata,       // epoch_seconds
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata,       // year, month_num, day_of_month,
	                                           // week_day, hour_val, minute_val,
	                                           // second_val, zero fill
	output logic                m_tuser        // out_of_range
);

	logic [OFFSET_W-1:0]    offset_q;
	logic [FIFO_AW:0]       credit_q;
	logic                   v_s1;
	logic [EPOCH_W-1:0]     epoch_s1;
	logic [PIPE_STAGES-1:0] vld_q;

	logic              s_acc, m_acc;
	logic [DAYS_W-1:0] days;
	logic [SOD_W-1:0]  sod;
	logic              oor_front, oor_done;
	e2c_date_t         date;
	e2c_clock_t        tod;
	e2c_result_t       res_in, res_out;

	assign s_acc = s_tvalid & s_tready;
	assign m_acc = m_tvalid & m_tready;

	// credits bound what is in the pipe plus what sits in the queue
	assign s_tready = (credit_q < (FIFO_AW+1)'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			credit_q <= '0;
			v_s1     <= 1'b0;
			vld_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				offset_q <= cfg_wr_data;
			end
			credit_q <= credit_q + (FIFO_AW+1)'(s_acc) - (FIFO_AW+1)'(m_acc);
			v_s1     <= s_acc;
			vld_q    <= {vld_q[PIPE_STAGES-2:0], v_s1};
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (s_acc) begin
			epoch_s1 <= s_tdata;
		end
	end

	// day count and seconds of day
	e2c_front u_front (
		.clk        (clk),
		.epoch      (epoch_s1),
		.utc_offset (offset_q),
		.days       (days),
		.sod        (sod),
		.oor        (oor_front)
	);

	// year, month, day and weekday; zeroed past 2099
	e2c_date u_date (
		.clk     (clk),
		.days    (days),
		.oor_in  (oor_front),
		.date    (date),
		.oor_out (oor_done)
	);

	// hour, minute, second; same depth as the date path
	e2c_clock u_clock (
		.clk (clk),
		.sod (sod),
		.tod (tod)
	);

	always_comb begin
		res_in.date         = date;
		res_in.tod          = oor_done ? '0 : tod;
		res_in.out_of_range = oor_done;
	end

	e2c_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (vld_q[PIPE_STAGES-1]),
		.wr_data   (res_in),
		.rd_en     (m_acc),
		.rd_data   (res_out),
		.not_empty (m_tvalid)
	);

	assign m_tdata = {
		7'd0,
		res_out.tod.second_val,
		res_out.tod.minute_val,
		res_out.tod.hour_val,
		res_out.date.week_day,
		res_out.date.day_of_month,
		res_out.date.month_num,
		res_out.date.year
	};
	assign m_tuser = res_out.out_of_range;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// unix seconds to calendar conversion, checked request by request against an
// in-bench calendar predictor while both stream sides idle and stall at random
module testbench;
	import e2c_pkg::*;

	// calendar facts used by the predictor
	localparam int unsigned DAY_SECS  = 86400;
	localparam int unsigned HOUR_SECS = 3600;
	localparam int unsigned QUAD_DAYS = 1461;   // 365 + 365 + 366 + 365, from 1970
	localparam int unsigned LAST_DAY  = 47482;  // day number of 2100-01-01

	// result field positions in m_tdata, lowest first
	localparam int MON_LSB  = YEAR_W;
	localparam int MDAY_LSB = MON_LSB + MONTH_W;
	localparam int WDAY_LSB = MDAY_LSB + MDAY_W;
	localparam int HOUR_LSB = WDAY_LSB + WDAY_W;
	localparam int MIN_LSB  = HOUR_LSB + HOUR_W;
	localparam int SEC_LSB  = MIN_LSB + MIN_W;
	localparam int FILL_LSB = SEC_LSB + SEC_W;

	// receiver stall patterns
	typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_HOLD} rx_mode_t;

	// one directed request: offset in force, epoch, and an optional typed-in answer
	typedef struct {
		logic [OFFSET_W-1:0] hours;
		logic [EPOCH_W-1:0]  epoch;
		bit                  fixed;
		e2c_result_t         want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [OFFSET_W-1:0] cfg_wr_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [EPOCH_W-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;

	e2c_result_t         calendar_due [$];   // dates still owed by the block, oldest first
	plan_row_t           plan [$];
	logic [OFFSET_W-1:0] offset_now = '0;    // offset the block holds, as far as we know
	int                  failures = 0;
	int                  burst_left = 0;
	rx_mode_t            rx_mode = RX_OPEN;
	int                  rx_run = 0;

	always #5 clk = ~clk;

	epoch_to_calendar u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),      // epoch_seconds
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),      // year, month_num, day_of_month, week_day,
		                             // hour_val, minute_val, second_val, zero fill
		.m_tuser     (m_tuser)       // out_of_range
	);

	// builds a result from plain numbers, for the typed-in table rows
	function automatic e2c_result_t calendar_value(int unsigned y, mo, d, wd, h, mi, s, bit oor);
		e2c_result_t r;
		r.date.year         = YEAR_W'(y);
		r.date.month_num    = MONTH_W'(mo);
		r.date.day_of_month = MDAY_W'(d);
		r.date.week_day     = WDAY_W'(wd);
		r.tod.hour_val      = HOUR_W'(h);
		r.tod.minute_val    = MIN_W'(mi);
		r.tod.second_val    = SEC_W'(s);
		r.out_of_range      = oor;
		return r;
	endfunction

	// predicted calendar date and time of day for one request
	function automatic e2c_result_t calendar_of(logic [EPOCH_W-1:0] epoch,
	                                            logic [OFFSET_W-1:0] hours);
		int unsigned     month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		longint unsigned secs, days, sod;
		int unsigned     yr, doy, mon, ylen, mlen;
		e2c_result_t     r;
		r = '0;
		// offset is added at full width, so a late epoch can run past 2099
		secs = 64'(epoch) + 64'(hours) * HOUR_SECS;
		days = secs / DAY_SECS;
		sod  = secs % DAY_SECS;
		if (days >= LAST_DAY) begin
			// beyond 2099 only the flag is set, every other field stays zero
			r.out_of_range = 1'b1;
			return r;
		end
		// whole four-year blocks first, then walk the remaining years
		yr   = 1970 + 4 * int'(days / QUAD_DAYS);
		doy  = int'(days % QUAD_DAYS);
		ylen = (yr % 4 == 0) ? 366 : 365;
		while (doy >= ylen) begin
			doy -= ylen;
			yr++;
			ylen = (yr % 4 == 0) ? 366 : 365;
		end
		// month walk, february gets its extra day in leap years
		mon  = 0;
		mlen = month_len[0];
		while (doy >= mlen) begin
			doy -= mlen;
			mon++;
			mlen = month_len[mon] + ((mon == 1 && yr % 4 == 0) ? 1 : 0);
		end
		// 1970-01-01 was a thursday, monday counts as 1
		r = calendar_value(yr, mon + 1, doy + 1, int'((days + 3) % 7) + 1,
			int'(sod / HOUR_SECS), int'((sod % HOUR_SECS) / 60), int'(sod % 60), 1'b0);
		return r;
	endfunction

	function automatic void check_field(string name, longint unsigned want, got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// random epoch, weighted toward the corners of the calendar
	function automatic logic [EPOCH_W-1:0] pick_epoch();
		longint days;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'd4102444799);
			6: begin
				// around the end of 2099 as seen through the current offset
				return EPOCH_W'(64'(LAST_DAY) * DAY_SECS - 64'(offset_now) * HOUR_SECS
					+ $urandom_range(0, 6) - 3);
			end
			7: begin
				// midnight edges, wrapping below zero on the first day
				days = $urandom_range(0, LAST_DAY);
				return EPOCH_W'(days * DAY_SECS - 64'(offset_now) * HOUR_SECS
					+ $urandom_range(0, 2) - 1);
			end
			8: return $urandom();
			default: begin
				// feb 28 / feb 29 / mar 1 in some leap year
				days = 64'($urandom_range(0, 32)) * QUAD_DAYS + 788 + $urandom_range(0, 2);
				return EPOCH_W'(days * DAY_SECS + $urandom_range(0, DAY_SECS - 1));
			end
		endcase
	endfunction

	// one request; the sender works in bursts with random gaps between them
	task automatic send_epoch(logic [EPOCH_W-1:0] epoch, e2c_result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		calendar_due.push_back(want);
		s_tvalid <= 1'b1;
		s_tdata  <= epoch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// every request yields a result, so an empty queue means the pipe is empty
	task automatic wait_drained();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (calendar_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_offset(logic [OFFSET_W-1:0] hours);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= hours;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		offset_now = hours;
	endtask

	// receiver: runs of always ready, coin flip, mostly stalled, or held off
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_run  = $urandom_range(8, 64);
		end
		rx_run--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
			default:   m_tready <= 1'b0;
		endcase
	end

	// result checker: every delivered date against the oldest one owed
	always @(posedge clk) begin
		e2c_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (calendar_due.size() == 0) begin
				$error("result delivered with no request outstanding");
				failures++;
			end else begin
				want = calendar_due.pop_front();
				check_field("year", want.date.year, m_tdata[0 +: YEAR_W]);
				check_field("month_num", want.date.month_num, m_tdata[MON_LSB +: MONTH_W]);
				check_field("day_of_month", want.date.day_of_month,
					m_tdata[MDAY_LSB +: MDAY_W]);
				check_field("week_day", want.date.week_day, m_tdata[WDAY_LSB +: WDAY_W]);
				check_field("hour_val", want.tod.hour_val, m_tdata[HOUR_LSB +: HOUR_W]);
				check_field("minute_val", want.tod.minute_val, m_tdata[MIN_LSB +: MIN_W]);
				check_field("second_val", want.tod.second_val, m_tdata[SEC_LSB +: SEC_W]);
				check_field("tdata fill", 0, m_tdata[TDATA_W-1:FILL_LSB]);
				check_field("out_of_range", want.out_of_range, m_tuser);
			end
		end
	end

	initial begin
		logic [OFFSET_W-1:0] hours;
		logic [EPOCH_W-1:0]  epoch;

		// directed rows, grouped by offset; typed-in answers where obvious
		plan = '{
			// reset offset: epoch start, last second of 2099, first second past it, largest epoch
			'{4'd0, 32'd0, 1'b1, calendar_value(1970, 1, 1, 4, 0, 0, 0, 1'b0)},
			'{4'd0, 32'd4102444799, 1'b1, calendar_value(2099, 12, 31, 4, 23, 59, 59, 1'b0)},
			'{4'd0, 32'd4102444800, 1'b1, calendar_value(0, 0, 0, 0, 0, 0, 0, 1'b1)},
			'{4'd0, 32'hFFFFFFFF, 1'b1, calendar_value(0, 0, 0, 0, 0, 0, 0, 1'b1)},
			// end of january, start of february
			'{4'd0, 32'd2678399, 1'b0, '0},
			'{4'd0, 32'd2678400, 1'b0, '0},
			// leap days and year ends in the first leap year and in 2000, then two bit patterns
			'{4'd0, 32'd68169600, 1'b0, '0},
			'{4'd0, 32'd68255999, 1'b0, '0},
			'{4'd0, 32'd94694399, 1'b0, '0},
			'{4'd0, 32'd94694400, 1'b0, '0},
			'{4'd0, 32'd951782400, 1'b0, '0},
			'{4'd0, 32'd978307199, 1'b0, '0},
			'{4'd0, 32'h55555555, 1'b0, '0},
			'{4'd0, 32'hAAAAAAAA, 1'b0, '0},
			// offset of fourteen hours
			'{4'd14, 32'd0, 1'b0, '0},
			'{4'd14, 32'd4102394400, 1'b0, '0},
			'{4'd14, 32'd4102394399, 1'b0, '0},
			// offset of fifteen, the largest the field holds, still adds its hours
			'{4'd15, 32'd4102390800, 1'b1, calendar_value(0, 0, 0, 0, 0, 0, 0, 1'b1)},
			'{4'd15, 32'd4102390799, 1'b0, '0},
			'{4'd15, 32'hFFFFFFFF, 1'b1, calendar_value(0, 0, 0, 0, 0, 0, 0, 1'b1)},
			'{4'd15, 32'd32400, 1'b0, '0},
			// one hour carries into the next day
			'{4'd1, 32'd82800, 1'b0, '0},
			'{4'd1, 32'd82799, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].hours != offset_now) begin
				wait_drained();
				write_offset(plan[i].hours);
			end
			send_epoch(plan[i].epoch,
				plan[i].fixed ? plan[i].want : calendar_of(plan[i].epoch, offset_now));
		end

		// random phases: the offset extremes first, then random settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       hours = 4'd15;
				1:       hours = 4'd0;
				2:       hours = 4'd14;
				default: hours = $urandom_range(0, 15);
			endcase
			wait_drained();
			write_offset(hours);
			repeat (100) begin
				epoch = pick_epoch();
				send_epoch(epoch, calendar_of(epoch, offset_now));
			end
		end

		// let anything stray come out after the last owed result
		wait_drained();
		repeat (24) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/e2c_pkg.sv
rtl/e2c_front.sv
rtl/e2c_date.sv
rtl/e2c_clock.sv
rtl/e2c_fifo.sv
rtl/epoch_to_calendar.sv
test/testbench.sv
